// ===== hw/rtl/plct_pkg.sv =====
package plct_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int PHASE_W_DEF   = 32;
    localparam int STAGES_DEF    = 16;
    localparam int TABLE_LEN     = 24;
    localparam int GUARD_BITS    = 8;
    localparam int CW            = SAMPLE_W + GUARD_BITS + 3;
    localparam int ZW            = 34;
    localparam int FIFO_DEPTH    = 4;
    localparam logic [16:0] INV_GAIN = 17'd39797;

    typedef enum logic [7:0] {
        CFG_ALPHA    = 8'd0,
        CFG_BETA     = 8'd1,
        CFG_MAX_FREQ = 8'd2,
        CFG_MIN_FREQ = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_i;
        logic signed [SAMPLE_W-1:0] sample_q;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_i;
        logic signed [SAMPLE_W-1:0] mixed_q;
    } t_out_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] si;
        logic signed [SAMPLE_W-1:0] sq;
        logic [31:0]                angle;
    } t_vec_item;

    typedef struct packed {
        logic [15:0]        alpha;
        logic [15:0]        beta;
        logic signed [31:0] max_freq;
        logic signed [31:0] min_freq;
    } t_loop_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // round(atan(2^-k) * 2^32 / (2*pi))
    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] v;
        case (k)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/plct_front.sv =====
module plct_front import plct_pkg::*; #(
    parameter int CORDIC_STAGES = STAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    input  logic      i_q_full,
    output logic      o_push,
    output t_vec_item o_vec
);

    localparam int N = CORDIC_STAGES;

    logic                         r_v  [0:N];
    logic signed [CW-1:0]         r_x  [0:N];
    logic signed [CW-1:0]         r_y  [0:N];
    logic [31:0]                  r_z  [0:N];
    logic                         r_zero [0:N];
    t_in_item                     r_s  [0:N];
    logic                         adv;
    logic signed [CW-1:0]         x0;
    logic signed [CW-1:0]         y0;

    assign adv     = !r_v[N] || !i_q_full;
    assign o_stall = !adv;
    assign o_push  = r_v[N] && adv;

    assign x0 = CW'(i_item.sample_i) <<< GUARD_BITS;
    assign y0 = CW'(i_item.sample_q) <<< GUARD_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
        end
        if (adv) begin
            // fold the left half plane onto the right
            if (x0 < 0) begin
                r_x[0] <= -x0;
                r_y[0] <= -y0;
                r_z[0] <= 32'h8000_0000;
            end else begin
                r_x[0] <= x0;
                r_y[0] <= y0;
                r_z[0] <= 32'd0;
            end
            r_zero[0] <= (i_item.sample_i == '0) && (i_item.sample_q == '0);
            r_s[0]    <= i_item;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_v[k+1] <= r_v[k];
            end
            if (adv) begin
                if (r_y[k] >= 0) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_turn(k);
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_turn(k);
                end
                r_zero[k+1] <= r_zero[k];
                r_s[k+1]    <= r_s[k];
            end
        end
    end

    assign o_vec.si    = r_s[N].sample_i;
    assign o_vec.sq    = r_s[N].sample_q;
    assign o_vec.angle = r_zero[N] ? 32'd0 : r_z[N];

endmodule

// ===== hw/rtl/plct_fifo.sv =====
module plct_fifo import plct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_vec_item i_data,
    input  logic      i_pop,
    output t_vec_item o_data,
    output t_q_status o_status
);

    localparam int AW = $clog2(FIFO_DEPTH);

    t_vec_item     r_mem [0:FIFO_DEPTH-1];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    assign o_status.full  = (r_cnt == (AW+1)'(FIFO_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_data         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

// ===== hw/rtl/plct_back.sv =====
module plct_back import plct_pkg::*; #(
    parameter int PHASE_WIDTH   = PHASE_W_DEF,
    parameter int CORDIC_STAGES = STAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_loop_cfg i_cfg,
    input  logic      i_q_empty,
    input  t_vec_item i_vec,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int N = CORDIC_STAGES;
    localparam logic [31:0] KEEP = 32'hFFFF_FFFF << (32 - PHASE_WIDTH);
    localparam int PW = CW + 18;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (15 + GUARD_BITS);
    localparam int SW = PW - 24;

    logic [31:0]          r_phase;
    logic signed [31:0]   r_freq;
    logic                 r_v [0:N];
    logic signed [CW-1:0] r_x [0:N];
    logic signed [CW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic                 r_pv;
    logic signed [PW-1:0] r_pi;
    logic signed [PW-1:0] r_pq;
    logic                 r_ov;
    t_out_item            r_out;
    logic                 adv;

    logic signed [31:0]   err;
    logic signed [48:0]   bprod;
    logic signed [48:0]   aprod;
    logic signed [32:0]   fsum;
    logic signed [31:0]   fnew;
    logic [31:0]          neg_p;
    logic signed [ZW-1:0] z0;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic                 flip;
    logic signed [SW-1:0] si_sh;
    logic signed [SW-1:0] sq_sh;

    assign adv     = !(r_ov && i_stall);
    assign o_pop   = !i_q_empty && adv;
    assign o_valid = r_ov;
    assign o_item  = r_out;

    // loop filter: error, integral path with clamp, phase advance
    always_comb begin
        err   = $signed(i_vec.angle - r_phase);
        bprod = $signed({1'b0, i_cfg.beta}) * err;
        aprod = $signed({1'b0, i_cfg.alpha}) * err;
        fsum  = 33'(r_freq) + 33'($signed(bprod[47:16]));
        if (fsum > 33'(i_cfg.max_freq)) begin
            fnew = i_cfg.max_freq;
        end else if (fsum < 33'(i_cfg.min_freq)) begin
            fnew = i_cfg.min_freq;
        end else begin
            fnew = fsum[31:0];
        end
        neg_p = -r_phase;
        z0    = ZW'($signed(neg_p));
        x0    = CW'(i_vec.si) <<< GUARD_BITS;
        y0    = CW'(i_vec.sq) <<< GUARD_BITS;
        flip  = (z0 > ZW'(33'sh0_4000_0000)) || (z0 < -ZW'(33'sh0_4000_0000));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_freq  <= '0;
            r_v[0]  <= 1'b0;
        end else begin
            if (adv) r_v[0] <= o_pop;
            if (o_pop) begin
                r_freq  <= fnew;
                r_phase <= (r_phase + fnew + aprod[47:16]) & KEEP;
            end
        end
        if (adv) begin
            if (flip) begin
                r_x[0] <= -x0;
                r_y[0] <= -y0;
                r_z[0] <= ZW'($signed(neg_p + 32'h8000_0000));
            end else begin
                r_x[0] <= x0;
                r_y[0] <= y0;
                r_z[0] <= z0;
            end
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_v[k+1] <= r_v[k];
            end
            if (adv) begin
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - ZW'(atan_turn(k));
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + ZW'(atan_turn(k));
                end
            end
        end
    end

    // gain correction, then round half up and saturate
    assign si_sh = SW'((r_pi + HALF) >>> (16 + GUARD_BITS));
    assign sq_sh = SW'((r_pq + HALF) >>> (16 + GUARD_BITS));

    function automatic logic signed [SAMPLE_W-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'({1'b0, {(SAMPLE_W-1){1'b1}}});
        lo = -hi - SW'(1);
        if (v > hi) return hi[SAMPLE_W-1:0];
        if (v < lo) return lo[SAMPLE_W-1:0];
        return v[SAMPLE_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_pv <= r_v[N];
            r_ov <= r_pv;
        end
        if (adv) begin
            r_pi <= PW'(r_x[N]) * PW'($signed({1'b0, INV_GAIN}));
            r_pq <= PW'(r_y[N]) * PW'($signed({1'b0, INV_GAIN}));
            r_out.mixed_i <= sat(si_sh);
            r_out.mixed_q <= sat(sq_sh);
        end
    end

endmodule

// ===== hw/rtl/pll_carrier_tracker.sv =====
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+--------------------------
// in       | request   | i_in_valid / o_in_stall      | i_in_data  (sample_i, q)
// out      | result    | o_out_valid / i_out_stall    | o_out_data (mixed_i, q)
// cfg      | write     | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while the output is not stalled. A request
// passes the front atan2 pipeline, the queue, then the back pipeline, whose
// rotation stages are followed by gain correction and rounding registers.
// The loop filter closes at the head of the back pipeline, on each queue pop.
// Reset (synchronous, active low) clears phase, frequency and gains and sets
// the clamps to the full range. Output stall freezes the back pipeline; the
// four-entry queue absorbs it before the front stalls its input.
module pll_carrier_tracker import plct_pkg::*; #(
    parameter int PHASE_WIDTH   = PHASE_W_DEF,
    parameter int CORDIC_STAGES = STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_loop_cfg r_cfg;
    t_vec_item push_vec;
    t_vec_item pop_vec;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // always ready: writes land directly in the gain and clamp registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha    <= '0;
            r_cfg.beta     <= '0;
            r_cfg.max_freq <= 32'sh7FFF_FFFF;
            r_cfg.min_freq <= 32'sh8000_0000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA:    r_cfg.alpha    <= i_cfg_data[15:0];
                CFG_BETA:     r_cfg.beta     <= i_cfg_data[15:0];
                CFG_MAX_FREQ: r_cfg.max_freq <= i_cfg_data;
                CFG_MIN_FREQ: r_cfg.min_freq <= i_cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // front: atan2 of each sample, depends on input alone
    plct_front #(.CORDIC_STAGES(CORDIC_STAGES)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_item   (i_in_data),
        .o_stall  (o_in_stall),
        .i_q_full (q_status.full),
        .o_push   (push),
        .o_vec    (push_vec)
    );

    plct_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_vec),
        .i_pop    (pop),
        .o_data   (pop_vec),
        .o_status (q_status)
    );

    // back: loop filter, then mixer rotation by the pre-update phase
    plct_back #(
        .PHASE_WIDTH   (PHASE_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_status.empty),
        .i_vec     (pop_vec),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out_data)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("queue pop while empty");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !q_status.full)
        else $error("pipeline not cleared by reset");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_status.full)
        else $error("input stalled with queue room");

endmodule
